// ===== sv/lfpc_pkg.sv =====
package lfpc_pkg;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       last_byte;
        logic       sender_busy;
    } in_item_t;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] pixel_index;
        logic [7:0] pixel_value;
        logic       last_of_item;
    } out_item_t;

    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_PIXEL = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;
    localparam logic [1:0] KIND_DROP  = 2'd3;

    localparam logic [1:0] FMT_NONE = 2'd0;
    localparam logic [1:0] FMT_MCUF = 2'd1;
    localparam logic [1:0] FMT_EBLP = 2'd2;
    localparam logic [1:0] FMT_BLP  = 2'd3;

    localparam logic [3:0] HEADER_LEN = 4'd12;
    localparam logic [7:0] FULL_SCALE = 8'd255;

    function automatic logic [7:0] magic_byte(input logic [1:0] fmt, input logic [1:0] pos);
        logic [7:0] r;
        r = 8'h00;
        case (fmt)
            FMT_MCUF: begin
                case (pos)
                    2'd0: r = 8'h23;
                    2'd1: r = 8'h54;
                    2'd2: r = 8'h26;
                    default: r = 8'h66;
                endcase
            end
            FMT_EBLP: begin
                case (pos)
                    2'd0: r = 8'hfe;
                    2'd1: r = 8'hed;
                    2'd2: r = 8'hbe;
                    default: r = 8'hef;
                endcase
            end
            FMT_BLP: begin
                case (pos)
                    2'd0: r = 8'hde;
                    2'd1: r = 8'had;
                    2'd2: r = 8'hbe;
                    default: r = 8'hef;
                endcase
            end
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // work item from front to back; width/height travel with the clear
    typedef struct packed {
        logic        do_clear;
        logic        do_pixel;
        logic [7:0]  value;
        logic        do_tail;
        logic [1:0]  tail_kind;
        logic [15:0] width;
        logic [15:0] height;
    } cmd_t;

endpackage

// ===== sv/led_frame_packet_converter.sv =====
// Frame packet decoder: one packet byte per transaction on s_, up to two result
// transactions per byte on m_. Header and plain pixel bytes are handled in the accept
// state alone. An MCUF byte that completes a pixel passes the accept, a channel-average
// divide state and a scale multiply state. MCUF header byte 11 passes the accept, a
// bit-serial 255/maxval divide and the area check. A 4-entry command queue
// separates the decoder from the result sequencer; a full queue stalls the input.
module led_frame_packet_converter import lfpc_pkg::*; #(
    parameter int SCREEN_WIDTH  = 16,
    parameter int SCREEN_HEIGHT = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic        fv, fr, qv, qr;
    cmd_t        fd, qd;

    lfpc_front #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .c_valid(fv), .c_ready(fr), .c_data(fd)
    );

    lfpc_queue u_queue (
        .aclk, .aresetn, .w_valid(fv), .w_ready(fr), .w_data(fd),
        .r_valid(qv), .r_ready(qr), .r_data(qd)
    );

    lfpc_back #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_back (
        .aclk, .aresetn, .c_valid(qv), .c_ready(qr), .c_data(qd),
        .m_valid, .m_ready, .m_data
    );

endmodule

// ===== sv/lfpc_front.sv =====
module lfpc_front import lfpc_pkg::*; #(
    parameter int SCREEN_WIDTH  = 16,
    parameter int SCREEN_HEIGHT = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      c_valid,
    input  logic      c_ready,
    output cmd_t      c_data
);

    localparam int unsigned AREA = SCREEN_WIDTH * SCREEN_HEIGHT;

    typedef enum logic [2:0] {
        ST_RUN  = 3'b001,
        ST_DIV  = 3'b010,
        ST_MUL  = 3'b100
    } state_t;

    state_t      state_reg, state_next;
    logic [3:0]  pos_reg, pos_next;
    logic [1:0]  fmt_reg, fmt_next;
    logic [15:0] fh_reg, fh_next;
    logic [15:0] fw_reg, fw_next;
    logic [15:0] cc_reg, cc_next;
    logic [7:0]  scale_reg, scale_next;
    logic [15:0] cpos_reg, cpos_next;
    logic [9:0]  sum_reg, sum_next;
    logic        drop_reg, drop_next;
    // channel average, 255/maxval divide, then scale multiply
    logic [9:0]  drem_reg, drem_next;
    logic [3:0]  dcnt_reg, dcnt_next;
    logic [1:0]  dused_reg, dused_next;
    logic        dlast_reg, dlast_next;
    logic        dsc_reg, dsc_next;
    logic [7:0]  dmv_reg, dmv_next;
    logic [7:0]  sq_reg, sq_next;
    logic [8:0]  srem_reg, srem_next;
    logic [31:0] prod_reg, prod_next;

    logic        cv_reg, cv_next;
    cmd_t        cd_reg, cd_next;

    logic        out_free;
    assign out_free = !cv_reg || c_ready;
    assign s_ready  = (state_reg == ST_RUN) && out_free;
    assign c_valid  = cv_reg;
    assign c_data   = cd_reg;

    logic [7:0] b;
    logic       last, busy;
    logic [1:0] used;
    logic [19:0] third;
    logic [9:0]  strial;

    always_comb begin
        state_next = state_reg;
        pos_next = pos_reg; fmt_next = fmt_reg; fh_next = fh_reg; fw_next = fw_reg;
        cc_next = cc_reg; scale_next = scale_reg; cpos_next = cpos_reg; sum_next = sum_reg;
        drop_next = drop_reg;
        drem_next = drem_reg; dcnt_next = dcnt_reg; dused_next = dused_reg;
        dlast_next = dlast_reg; dsc_next = dsc_reg; dmv_next = dmv_reg;
        sq_next = sq_reg; srem_next = srem_reg; prod_next = prod_reg;
        cv_next = cv_reg && !c_ready;
        cd_next = cd_reg;
        b = s_data.packet_byte; last = s_data.last_byte; busy = s_data.sender_busy;
        used = (cc_reg == 16'd3) ? 2'd3 : (cc_reg == 16'd2) ? 2'd2 : 2'd1;
        third = '0;
        strial = '0;
        case (state_reg)
            ST_RUN: begin
                if (s_valid && s_ready) begin
                    cd_next = '0;
                    if (!drop_reg) begin
                        if (pos_reg == 4'd0) begin
                            fh_next = '0; fw_next = '0; cc_next = 16'd1; scale_next = 8'd1;
                            cpos_next = '0; sum_next = '0;
                            fmt_next = (b == 8'h23) ? FMT_MCUF : (b == 8'hfe) ? FMT_EBLP :
                                       (b == 8'hde) ? FMT_BLP : FMT_NONE;
                            if (busy || fmt_next == FMT_NONE) drop_next = 1'b1;
                        end else if (pos_reg < 4'd4) begin
                            if (b != magic_byte(fmt_reg, pos_reg[1:0])) drop_next = 1'b1;
                        end else if (pos_reg < HEADER_LEN) begin
                            if (fmt_reg == FMT_MCUF) begin
                                case (pos_reg)
                                    4'd4: fh_next = {b, 8'd0};
                                    4'd5: fh_next = {fh_reg[15:8], b};
                                    4'd6: fw_next = {b, 8'd0};
                                    4'd7: fw_next = {fw_reg[15:8], b};
                                    4'd8: cc_next = {b, 8'd0};
                                    4'd9: cc_next = {cc_reg[15:8], b};
                                    4'd10: sum_next = {2'd0, b};
                                    default: ;
                                endcase
                            end else begin
                                case (pos_reg)
                                    4'd8: fw_next = {b, 8'd0};
                                    4'd9: fw_next = {fw_reg[15:8], b};
                                    4'd10: fh_next = {b, 8'd0};
                                    4'd11: fh_next = {fh_reg[15:8], b};
                                    default: ;
                                endcase
                            end
                            if (pos_reg == 4'd11) begin
                                if (fmt_reg == FMT_MCUF) begin
                                    dmv_next = (sum_reg != 10'd0) ? FULL_SCALE :
                                               (b == 8'd0) ? 8'd1 : b;
                                    if (cc_reg == 16'd0) cc_next = 16'd1;
                                    sum_next = '0;
                                    sq_next = '0; srem_next = '0; dcnt_next = '0;
                                    prod_next = {16'd0, fh_reg} * {16'd0, fw_reg};
                                    dlast_next = last;
                                    state_next = ST_DIV;
                                    dsc_next = 1'b1;
                                end else begin
                                    cd_next.do_clear = 1'b1;
                                    cd_next.width = fw_next;
                                    cd_next.height = fh_next;
                                end
                            end
                        end else if (fmt_reg == FMT_MCUF) begin
                            if (cpos_reg < {14'd0, used})
                                sum_next = sum_reg + {2'd0, b};
                            if ({1'b0, cpos_reg} + 17'd1 >= {1'b0, cc_reg}) begin
                                sum_next = '0;
                                cpos_next = '0;
                                drem_next = (cpos_reg < {14'd0, used}) ?
                                            sum_reg + {2'd0, b} : sum_reg;
                                dused_next = used;
                                dlast_next = last; dsc_next = 1'b0;
                                state_next = ST_DIV;
                            end else begin
                                cpos_next = cpos_reg + 16'd1;
                            end
                        end else if (fmt_reg == FMT_EBLP) begin
                            cd_next.do_pixel = 1'b1; cd_next.value = b;
                        end else begin
                            cd_next.do_pixel = 1'b1;
                            cd_next.value = (b != 8'd0) ? FULL_SCALE : 8'd0;
                        end
                        if (state_next == ST_RUN) begin
                            if (drop_next) begin
                                cd_next.do_tail = 1'b1; cd_next.tail_kind = KIND_DROP;
                            end else if (pos_reg < HEADER_LEN) begin
                                pos_next = pos_reg + 4'd1;
                            end
                        end
                    end
                    if (state_next == ST_RUN) begin
                        if (last) begin
                            if (!drop_reg && !drop_next) begin
                                cd_next.do_tail = 1'b1;
                                cd_next.tail_kind = (pos_next < HEADER_LEN) ? KIND_DROP
                                                                             : KIND_DONE;
                            end
                            pos_next = '0;
                            drop_next = 1'b0;
                        end
                        cv_next = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                if (dsc_reg) begin
                    // 255 / maxval, restoring, one bit per cycle
                    strial = {srem_reg, FULL_SCALE[3'd7 - dcnt_reg[2:0]]};
                    if (strial >= {2'd0, dmv_reg}) begin
                        srem_next = 9'(strial - {2'd0, dmv_reg});
                        sq_next = {sq_reg[6:0], 1'b1};
                    end else begin
                        srem_next = strial[8:0];
                        sq_next = {sq_reg[6:0], 1'b0};
                    end
                    dcnt_next = dcnt_reg + 4'd1;
                    if (dcnt_reg == 4'd7) state_next = ST_MUL;
                end else begin
                    // sum / used; divide by 3 as multiply by 683/2048, exact below 1024
                    third = {10'd0, drem_reg} * 20'd683;
                    case (dused_reg)
                        2'd3: prod_next = {23'd0, third[19:11]};
                        2'd2: prod_next = {23'd0, drem_reg[9:1]};
                        default: prod_next = {22'd0, drem_reg};
                    endcase
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (out_free) begin
                    cd_next = '0;
                    state_next = ST_RUN;
                    if (dsc_reg) begin
                        scale_next = sq_reg;
                        if (prod_reg > 32'(AREA)) begin
                            drop_next = 1'b1;
                            cd_next.do_tail = 1'b1; cd_next.tail_kind = KIND_DROP;
                        end else begin
                            cd_next.do_clear = 1'b1;
                            cd_next.width = fw_reg;
                            cd_next.height = fh_reg;
                            pos_next = pos_reg + 4'd1;
                        end
                    end else begin
                        cd_next.do_pixel = 1'b1;
                        cd_next.value = 8'(prod_reg[7:0] * scale_reg);
                    end
                    if (dlast_reg) begin
                        if (!drop_next) begin
                            cd_next.do_tail = 1'b1;
                            cd_next.tail_kind = (pos_next < HEADER_LEN) ? KIND_DROP
                                                                         : KIND_DONE;
                        end
                        pos_next = '0;
                        drop_next = 1'b0;
                    end
                    cv_next = 1'b1;
                end
            end
            default: state_next = ST_RUN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RUN;
            pos_reg <= '0; fmt_reg <= FMT_NONE; fh_reg <= '0; fw_reg <= '0;
            cc_reg <= 16'd1; scale_reg <= 8'd1; cpos_reg <= '0; sum_reg <= '0;
            drop_reg <= 1'b0; cv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pos_reg <= pos_next; fmt_reg <= fmt_next; fh_reg <= fh_next; fw_reg <= fw_next;
            cc_reg <= cc_next; scale_reg <= scale_next; cpos_reg <= cpos_next;
            sum_reg <= sum_next; drop_reg <= drop_next; cv_reg <= cv_next;
        end
        cd_reg <= cd_next;
        drem_reg <= drem_next; dcnt_reg <= dcnt_next;
        dused_reg <= dused_next; dlast_reg <= dlast_next; dsc_reg <= dsc_next;
        dmv_reg <= dmv_next; sq_reg <= sq_next; srem_reg <= srem_next; prod_reg <= prod_next;
    end

endmodule

// ===== sv/lfpc_queue.sv =====
module lfpc_queue import lfpc_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic w_valid,
    output logic w_ready,
    input  cmd_t w_data,
    output logic r_valid,
    input  logic r_ready,
    output cmd_t r_data
);

    cmd_t       mem [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic       wr, rd;

    assign w_ready = cnt_reg != 3'd4;
    assign r_valid = cnt_reg != 3'd0;
    assign r_data  = mem[rp_reg];
    assign wr = w_valid && w_ready;
    assign rd = r_valid && r_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= wp_reg + 2'd1;
            if (rd) rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'd0, wr} - {2'd0, rd};
        end
        if (wr) mem[wp_reg] <= w_data;
    end

endmodule

// ===== sv/lfpc_back.sv =====
module lfpc_back import lfpc_pkg::*; #(
    parameter int SCREEN_WIDTH  = 16,
    parameter int SCREEN_HEIGHT = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        c_valid,
    output logic        c_ready,
    input  cmd_t        c_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data
);

    logic [15:0] col_reg, col_next;
    logic [15:0] row_reg, row_next;
    logic [15:0] fw_reg, fw_next;
    logic [15:0] fh_reg, fh_next;
    logic [1:0]  phase_reg, phase_next;
    logic        mv_reg, mv_next;
    out_item_t   md_reg, md_next;
    logic        out_free, on_screen, has_tail, has_main;
    logic [1:0]  kind;
    logic [7:0]  idx;
    logic [31:0] lin;

    assign out_free = !mv_reg || m_ready;
    assign m_valid = mv_reg;
    assign m_data = md_reg;

    always_comb begin
        on_screen = col_reg < fw_reg && row_reg < fh_reg &&
                    {16'd0, col_reg} < 32'(SCREEN_WIDTH) &&
                    {16'd0, row_reg} < 32'(SCREEN_HEIGHT);
        has_main = c_data.do_clear || (c_data.do_pixel && on_screen);
        has_tail = c_data.do_tail;
        kind = c_data.do_clear ? KIND_CLEAR : KIND_PIXEL;
        lin = {16'd0, col_reg} + {16'd0, row_reg} * 32'(SCREEN_WIDTH);
        idx = c_data.do_pixel ? lin[7:0] : 8'd0;
        col_next = col_reg; row_next = row_reg; phase_next = phase_reg;
        fw_next = fw_reg; fh_next = fh_reg;
        mv_next = mv_reg && !m_ready; md_next = md_reg;
        c_ready = 1'b0;
        if (c_valid && out_free) begin
            if (phase_reg == 2'd0 && has_main) begin
                mv_next = 1'b1;
                md_next = '{result_kind: kind, pixel_index: idx,
                            pixel_value: c_data.do_pixel ? c_data.value : 8'd0,
                            last_of_item: !has_tail};
                if (has_tail) phase_next = 2'd1;
                else c_ready = 1'b1;
            end else begin
                if (has_tail) begin
                    mv_next = 1'b1;
                    md_next = '{result_kind: c_data.tail_kind, pixel_index: 8'd0,
                                pixel_value: 8'd0, last_of_item: 1'b1};
                end
                c_ready = 1'b1;
                phase_next = 2'd0;
            end
            if (c_ready) begin
                if (c_data.do_clear) begin
                    col_next = '0; row_next = '0;
                    fw_next = c_data.width; fh_next = c_data.height;
                end
                if (c_data.do_pixel) begin
                    if ({1'b0, col_reg} + 17'd1 < {1'b0, fw_reg}) begin
                        col_next = col_reg + 16'd1;
                    end else begin
                        col_next = '0;
                        if (row_reg != 16'hFFFF) row_next = row_reg + 16'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0; row_reg <= '0; phase_reg <= '0; mv_reg <= 1'b0;
            fw_reg <= '0; fh_reg <= '0;
        end else begin
            col_reg <= col_next; row_reg <= row_next;
            phase_reg <= phase_next; mv_reg <= mv_next;
            fw_reg <= fw_next; fh_reg <= fh_next;
        end
        md_reg <= md_next;
    end

endmodule

// ===== sim/lfpc_checker.sv =====
module lfpc_checker import lfpc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_item_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_item_t m_data,
    output int        fail_count,
    output int        pending
);
    localparam int SCR_W = 16;
    localparam int SCR_H = 16;

    out_item_t expected_q[$];

    int unsigned pos_r, height_r, width_r, chans_r, scale_r, chpos_r, sum_r, col_r, row_r;
    logic [1:0]  fmt_r;
    bit          drop_r;

    function automatic void push_result(logic [1:0] kind, int unsigned idx, int unsigned val);
        out_item_t r;
        r.result_kind  = kind;
        r.pixel_index  = idx[7:0];
        r.pixel_value  = val[7:0];
        r.last_of_item = 1'b0;
        expected_q.push_back(r);
    endfunction

    function automatic void place_pixel(int unsigned val);
        if (col_r < width_r && row_r < height_r && col_r < SCR_W && row_r < SCR_H)
            push_result(KIND_PIXEL, col_r + row_r * SCR_W, val);
        if (col_r + 1 < width_r) begin
            col_r++;
        end else begin
            col_r = 0;
            if (row_r < 16'hffff)
                row_r++;
        end
    endfunction

    function automatic void decode_byte(in_item_t it);
        int unsigned b, used, mv, v;
        int          n0;
        bit          was_drop;
        b = it.packet_byte;
        was_drop = drop_r;
        n0 = expected_q.size();
        if (!drop_r) begin
            if (pos_r == 0) begin
                height_r = 0; width_r = 0; chans_r = 1; scale_r = 1;
                chpos_r = 0; sum_r = 0; col_r = 0; row_r = 0;
                fmt_r = (b == 8'h23) ? FMT_MCUF : (b == 8'hfe) ? FMT_EBLP :
                        (b == 8'hde) ? FMT_BLP : FMT_NONE;
                if (it.sender_busy || fmt_r == FMT_NONE)
                    drop_r = 1;
            end else if (pos_r < 4) begin
                if (fmt_r == FMT_MCUF && b != (pos_r == 1 ? 8'h54 : pos_r == 2 ? 8'h26 : 8'h66))
                    drop_r = 1;
                if (fmt_r != FMT_MCUF && b != (pos_r == 1 ? (fmt_r == FMT_EBLP ? 8'hed : 8'had)
                                               : pos_r == 2 ? 8'hbe : 8'hef))
                    drop_r = 1;
            end else if (pos_r < 12) begin
                if (fmt_r == FMT_MCUF) begin
                    case (pos_r)
                        4: height_r = b << 8;
                        5: height_r |= b;
                        6: width_r = b << 8;
                        7: width_r |= b;
                        8: chans_r = b << 8;
                        9: chans_r |= b;
                        10: sum_r = b;
                        default: ;
                    endcase
                end else begin
                    case (pos_r)
                        8: width_r = b << 8;
                        9: width_r |= b;
                        10: height_r = b << 8;
                        11: height_r |= b;
                        default: ;
                    endcase
                end
                if (pos_r == 11) begin
                    if (fmt_r == FMT_MCUF) begin
                        mv = (sum_r != 0) ? 255 : b;
                        if (mv == 0)
                            mv = 1;
                        scale_r = 255 / mv;
                        if (chans_r == 0)
                            chans_r = 1;
                        sum_r = 0;
                        if (height_r * width_r > SCR_W * SCR_H)
                            drop_r = 1;
                    end
                    if (!drop_r)
                        push_result(KIND_CLEAR, 0, 0);
                end
            end else if (fmt_r == FMT_MCUF) begin
                used = (chans_r == 3) ? 3 : (chans_r == 2) ? 2 : 1;
                if (chpos_r < used)
                    sum_r = (sum_r + b) & 10'h3ff;
                if (chpos_r + 1 >= chans_r) begin
                    v = ((sum_r / used) * scale_r) & 8'hff;
                    sum_r = 0;
                    chpos_r = 0;
                    place_pixel(v);
                end else begin
                    chpos_r++;
                end
            end else if (fmt_r == FMT_EBLP) begin
                place_pixel(b);
            end else begin
                place_pixel(b != 0 ? 255 : 0);
            end
            if (drop_r)
                push_result(KIND_DROP, 0, 0);
            else if (pos_r < 12)
                pos_r++;
        end
        if (it.last_byte) begin
            if (!was_drop && !drop_r)
                push_result(pos_r < 12 ? KIND_DROP : KIND_DONE, 0, 0);
            pos_r = 0;
            drop_r = 0;
        end
        if (expected_q.size() > n0)
            expected_q[expected_q.size() - 1].last_of_item = 1'b1;
    endfunction

    always @(posedge aclk) begin
        out_item_t e;
        if (!aresetn) begin
            pos_r = 0; fmt_r = FMT_NONE; height_r = 0; width_r = 0; chans_r = 1;
            scale_r = 1; chpos_r = 0; sum_r = 0; col_r = 0; row_r = 0; drop_r = 0;
            fail_count <= 0;
            pending <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result transaction %p", m_data);
                    fail_count <= fail_count + 1;
                end else begin
                    e = expected_q.pop_front();
                    if (e.result_kind !== m_data.result_kind)
                        $error("result_kind exp %0d got %0d", e.result_kind, m_data.result_kind);
                    if (e.pixel_index !== m_data.pixel_index)
                        $error("pixel_index exp %0d got %0d", e.pixel_index, m_data.pixel_index);
                    if (e.pixel_value !== m_data.pixel_value)
                        $error("pixel_value exp %0d got %0d", e.pixel_value, m_data.pixel_value);
                    if (e.last_of_item !== m_data.last_of_item)
                        $error("last_of_item exp %0d got %0d", e.last_of_item,
                               m_data.last_of_item);
                    if (e !== m_data)
                        fail_count <= fail_count + 1;
                end
            end
            if (s_valid && s_ready)
                decode_byte(s_data);
            pending <= expected_q.size();
        end
    end
endmodule

// ===== sim/tb.sv =====
module tb;
    import lfpc_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;
    int        fail_count;
    int        pending;
    int        idle_cycles;
    bit        sending_done;
    bit        hold_rx;

    in_item_t  byte_q[$];

    led_frame_packet_converter dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    lfpc_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    function automatic void add_byte(int unsigned b, bit last = 0, bit busy = 0);
        in_item_t it;
        it.packet_byte = b[7:0];
        it.last_byte   = last;
        it.sender_busy = busy;
        byte_q.push_back(it);
    endfunction

    function automatic void add_magic(int fmt);
        case (fmt)
            FMT_MCUF: begin add_byte(8'h23); add_byte(8'h54); add_byte(8'h26); add_byte(8'h66); end
            FMT_EBLP: begin add_byte(8'hfe); add_byte(8'hed); add_byte(8'hbe); add_byte(8'hef); end
            default:  begin add_byte(8'hde); add_byte(8'had); add_byte(8'hbe); add_byte(8'hef); end
        endcase
    endfunction

    // whole packet: header then body bytes, last flag on final byte
    function automatic void add_packet(int fmt, int unsigned h, int unsigned w,
                                       int unsigned ch, int unsigned mv, int body);
        add_magic(fmt);
        if (fmt == FMT_MCUF) begin
            add_byte(h >> 8); add_byte(h); add_byte(w >> 8); add_byte(w);
            add_byte(ch >> 8); add_byte(ch); add_byte(mv >> 8);
            add_byte(mv, body == 0);
        end else begin
            add_byte($urandom); add_byte($urandom); add_byte($urandom); add_byte($urandom);
            add_byte(w >> 8); add_byte(w); add_byte(h >> 8);
            add_byte(h, body == 0);
        end
        for (int i = 0; i < body; i++)
            add_byte($urandom_range(0, 3) == 0 ? 0 : $urandom, i == body - 1);
    endfunction

    task automatic send_all();
        in_item_t it;
        int burst;
        int gap;
        burst = 0;
        while (byte_q.size() > 0) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 30);
                gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
            it = byte_q.pop_front();
            s_valid <= 1'b1;
            s_data  <= it;
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
            @(negedge aclk);
            burst--;
        end
        s_valid <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin
        int f, h, w;
        s_valid = 0;
        s_data  = '0;
        hold_rx = 0;
        aresetn = 0;
        repeat (3) @(negedge aclk);
        aresetn = 1;
        // directed
        add_packet(FMT_MCUF, 2, 3, 3, 255, 18);
        add_packet(FMT_MCUF, 16, 16, 1, 0, 4);
        add_packet(FMT_MCUF, 1, 2, 2, 300, 5);
        add_packet(FMT_MCUF, 1, 1, 0, 7, 3);
        add_packet(FMT_MCUF, 17, 16, 1, 255, 2);
        add_packet(FMT_EBLP, 20, 20, 0, 0, 30);
        add_packet(FMT_BLP, 2, 2, 0, 0, 6);
        add_byte(8'h23, 0, 1); add_byte(8'h00, 1);
        add_byte(8'h55, 1);
        add_byte(8'hde); add_byte(8'had); add_byte(8'hbf); add_byte(8'h00, 1);
        add_byte(8'hfe); add_byte(8'hed, 1);
        add_packet(FMT_MCUF, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1);
        send_all();
        // pause until drained
        wait (pending == 0);
        hold_rx = 1;
        add_packet(FMT_EBLP, 16, 16, 0, 0, 40);
        send_all();
        hold_rx = 0;
        wait (pending == 0);
        repeat (40) @(negedge aclk);
        for (int p = 0; p < 15; p++) begin
            f = $urandom_range(1, 3);
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 16);
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 16);
            if ($urandom_range(0, 9) == 0) begin
                add_byte($urandom, 0, $urandom_range(0, 1));
                add_byte($urandom, 1);
            end else begin
                add_packet(f, h, w, $urandom_range(0, 4), $urandom_range(0, 300),
                           $urandom_range(0, 30));
            end
        end
        send_all();
        sending_done = 1;
    end

    initial begin
        bit held;
        m_ready = 0;
        held = 0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_rx && !held) begin
                held = 1;
                m_ready <= 1'b0;
                repeat (300) @(negedge aclk);
            end else begin
                if (!hold_rx)
                    held = 0;
                m_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
            end
        end
    end

    initial begin
        idle_cycles = 0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        wait (sending_done);
        wait (pending == 0);
        repeat (100) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
